### src/mcit_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcit_pkg
// Shared types and constants of the multi-channel interval timer.
// ----------------------------------------------------------------------------
package mcit_pkg;

  localparam int NUM_SLOTS_DEF = 16;
  localparam int PCT_FULL      = 100;
  localparam int PROG_W        = 7;

  localparam logic [3:0] CMD_TICK       = 4'd0;
  localparam logic [3:0] CMD_CREATE     = 4'd1;
  localparam logic [3:0] CMD_DESTROY    = 4'd2;
  localparam logic [3:0] CMD_PAUSE      = 4'd3;
  localparam logic [3:0] CMD_RESUME     = 4'd4;
  localparam logic [3:0] CMD_RESTART    = 4'd5;
  localparam logic [3:0] CMD_SET_IVAL   = 4'd6;
  localparam logic [3:0] CMD_QUERY      = 4'd7;
  localparam logic [3:0] CMD_PAUSE_ALL  = 4'd8;
  localparam logic [3:0] CMD_RESUME_ALL = 4'd9;
  localparam logic [3:0] CMD_KILL_ALL   = 4'd10;

  localparam logic [1:0] KIND_FIRED  = 2'd0;
  localparam logic [1:0] KIND_DONE   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;
  localparam logic [1:0] KIND_QUERY  = 2'd3;

  typedef struct packed {
    logic [31:0] interval;
    logic [31:0] elapsed;
    logic [15:0] repeats;
  } slot_entry_t;

  typedef struct packed {
    logic              done;
    logic [PROG_W-1:0] prog;
  } div_rsp_t;

endpackage
`default_nettype wire

### src/mcit_progress.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcit_progress
// Percent progress elapsed*100/interval capped at 100 (0 for a zero interval), one quotient bit a cycle.
// ----------------------------------------------------------------------------
module mcit_progress (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [31:0]      elapsed,
  input  wire logic [31:0]      interval,
  output mcit_pkg::div_rsp_t    rsp
);

  typedef enum logic [1:0] {D_IDLE, D_MUL, D_DIV, D_OUT} dstate_t;

  localparam int NW = 32 + mcit_pkg::PROG_W;

  dstate_t                     state;
  logic [31:0]                 el_r;
  logic [31:0]                 iv_r;
  logic                        full;
  logic                        zero;
  logic [NW-1:0]               num;
  logic [NW-1:0]               dv;
  logic [2:0]                  bitn;
  logic [mcit_pkg::PROG_W-1:0] q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
    end else begin
      unique case (state)
        D_IDLE: begin
          if (start) begin
            el_r  <= elapsed;
            iv_r  <= interval;
            full  <= (elapsed >= interval);
            zero  <= (interval == 32'd0);
            state <= D_MUL;
          end
        end
        D_MUL: begin
          num   <= NW'(el_r) * NW'(mcit_pkg::PCT_FULL);
          dv    <= NW'(iv_r) << (mcit_pkg::PROG_W - 1);
          bitn  <= 3'(mcit_pkg::PROG_W - 1);
          q     <= '0;
          state <= D_DIV;
        end
        D_DIV: begin
          if (num >= dv) begin
            num     <= num - dv;
            q[bitn] <= 1'b1;
          end
          dv <= dv >> 1;
          if (bitn == 3'd0) state <= D_OUT;
          else bitn <= bitn - 3'd1;
        end
        D_OUT: state <= D_IDLE;
        default: state <= D_IDLE;
      endcase
    end
  end

  always_comb begin
    rsp.done = (state == D_OUT);
    if (zero) rsp.prog = '0;
    else if (full) rsp.prog = mcit_pkg::PROG_W'(mcit_pkg::PCT_FULL);
    else rsp.prog = q;
  end

endmodule
`default_nettype wire

### src/multi_channel_interval_timer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_channel_interval_timer
// Bank of timer slots driven by tick and slot commands, with fired results.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                                        tuser  tlast
//  s_        in   slot_id,time_value,repeating,repeat_count    cmd    -
//  m_        out  ok,slot,remaining,elapsed_now,progress,...   kind   last
//
// A tick walks every slot in turn (memory read, then write back), then
// steps through the slots to emit fired results, then the done result.
// Query waits on the progress divider. Interval, elapsed and repeat count
// sit in one synchronous memory; active, paused and repeating flags sit in
// flip-flops cleared by rst. A result waiting at the output stalls the
// sequencer only when the next result is ready.
// ----------------------------------------------------------------------------
module multi_channel_interval_timer #(
  parameter int NUM_SLOTS = mcit_pkg::NUM_SLOTS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // slot_id[3:0], time_value[35:4], repeating[36], repeat_count[52:37]
  input  wire logic [55:0]  s_tdata,
  // command[3:0]
  input  wire logic [3:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // ok[0], slot[4:1], remaining[36:5], elapsed_now[68:37], progress[75:69],
  // is_active[76], is_paused[77], active_count[82:78], total_elapsed[114:83],
  // system_paused[115]
  output logic [119:0]      m_tdata,
  // kind[1:0]
  output logic [1:0]        m_tuser,
  output logic              m_tlast
);

  localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW = $clog2(NUM_SLOTS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_TRD, S_TWR, S_TEMIT, S_MRD, S_MWR, S_QWAIT, S_OUT
  } state_t;

  state_t                 state;
  logic [3:0]             cmd;
  logic [31:0]            tv;
  logic [CW-1:0]          idx;
  logic [IW-1:0]          sid;
  logic [NUM_SLOTS-1:0]   act;
  logic [NUM_SLOTS-1:0]   pau;
  logic [NUM_SLOTS-1:0]   rep;
  logic [NUM_SLOTS-1:0]   fired;
  logic [CW-1:0]          live;
  logic [31:0]            total;
  logic                   gpause;

  logic [1:0]             r_kind;
  logic                   r_ok;
  logic [3:0]             r_slot;
  logic [31:0]            r_rem;
  logic [31:0]            r_el;
  logic [6:0]             r_prog;
  logic                   r_act;
  logic                   r_pau;

  mcit_pkg::slot_entry_t  mem [NUM_SLOTS];
  mcit_pkg::slot_entry_t  rd_data;
  mcit_pkg::slot_entry_t  wdata;
  logic                   mem_we;
  logic                   mem_re;
  logic [IW-1:0]          waddr;
  logic [IW-1:0]          raddr;

  logic                   out_free;
  logic                   out_load;
  logic                   in_fire;
  logic [3:0]             in_cmd;
  logic [3:0]             in_id;
  logic [31:0]            in_tv;
  logic                   in_rep;
  logic [15:0]            in_cnt;
  logic                   id_ok;
  logic [IW-1:0]          in_sid;
  logic                   free_any;
  logic [IW-1:0]          free_idx;
  logic [IW-1:0]          ti;
  logic                   t_run;
  logic [32:0]            t_sum;
  logic [31:0]            t_el;
  logic                   t_fire;
  logic                   q_start;
  mcit_pkg::div_rsp_t     div_rsp;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign in_cmd   = s_tuser;
  assign in_id    = s_tdata[3:0];
  assign in_tv    = s_tdata[35:4];
  assign in_rep   = s_tdata[36];
  assign in_cnt   = s_tdata[52:37];
  assign id_ok    = (32'(in_id) < NUM_SLOTS);
  assign in_sid   = IW'(in_id);
  assign ti       = idx[IW-1:0];

  // load the output register with a fired or a final result
  assign out_load = out_free && ((state == S_OUT) ||
                    ((state == S_TEMIT) && (32'(idx) != NUM_SLOTS) && fired[ti]));

  // first free slot, lowest index wins
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!act[i]) begin
        free_any = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  // tick update of the slot just read
  always_comb begin
    t_run  = act[ti] && !pau[ti];
    t_sum  = 33'(rd_data.elapsed) + 33'(tv);
    t_el   = t_sum[32] ? 32'hFFFF_FFFF : t_sum[31:0];
    t_fire = t_run && (t_el >= rd_data.interval);
  end

  always_comb begin
    mem_we = 1'b0;
    waddr  = sid;
    wdata  = rd_data;
    mem_re = (state == S_TRD) || (state == S_MRD);
    raddr  = (state == S_TRD) ? ti : sid;
    unique case (state)
      S_IDLE: begin
        waddr          = free_idx;
        wdata.interval = in_tv;
        wdata.elapsed  = '0;
        wdata.repeats  = in_cnt;
        mem_we         = in_fire && (in_cmd == mcit_pkg::CMD_CREATE) && free_any;
      end
      S_TWR: begin
        waddr         = ti;
        mem_we        = t_run;
        wdata.elapsed = t_el;
        if (t_fire && rep[ti]) begin
          wdata.elapsed = '0;
          if (rd_data.repeats != 16'd0) wdata.repeats = rd_data.repeats - 16'd1;
        end
      end
      S_MWR: begin
        if (cmd == mcit_pkg::CMD_RESTART) begin
          mem_we        = 1'b1;
          wdata.elapsed = '0;
        end else if (cmd == mcit_pkg::CMD_SET_IVAL) begin
          mem_we         = 1'b1;
          wdata.interval = tv;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    if (mem_re) rd_data <= mem[raddr];
  end

  assign q_start = (state == S_MWR) && (cmd == mcit_pkg::CMD_QUERY) && act[sid];

  mcit_progress u_progress (
    .clk      (clk),
    .rst      (rst),
    .start    (q_start),
    .elapsed  (rd_data.elapsed),
    .interval (rd_data.interval),
    .rsp      (div_rsp)
  );

  function automatic logic [119:0] pack_out(
    input logic ok, input logic [3:0] slot, input logic [31:0] rem,
    input logic [31:0] el, input logic [6:0] prog, input logic a, input logic p,
    input logic [4:0] cnt, input logic [31:0] tot, input logic gp);
    pack_out = {4'd0, gp, tot, cnt, p, a, prog, el, rem, slot, ok};
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      act      <= '0;
      pau      <= '0;
      rep      <= '0;
      live     <= '0;
      total    <= '0;
      gpause   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            cmd    <= in_cmd;
            tv     <= in_tv;
            sid    <= in_sid;
            r_kind <= mcit_pkg::KIND_STATUS;
            r_ok   <= 1'b1;
            r_slot <= 4'd0;
            r_rem  <= '0;
            r_el   <= '0;
            r_prog <= '0;
            r_act  <= 1'b0;
            r_pau  <= 1'b0;
            state  <= S_OUT;
            unique case (in_cmd)
              mcit_pkg::CMD_TICK: begin
                fired <= '0;
                idx   <= '0;
                if (!gpause) begin
                  total <= total + in_tv;
                  state <= S_TRD;
                end else begin
                  r_kind <= mcit_pkg::KIND_DONE;
                end
              end
              mcit_pkg::CMD_CREATE: begin
                if (free_any) begin
                  act[free_idx] <= 1'b1;
                  pau[free_idx] <= 1'b0;
                  rep[free_idx] <= in_rep;
                  live          <= live + CW'(1);
                  r_slot        <= 4'(free_idx);
                end else begin
                  r_ok <= 1'b0;
                end
              end
              mcit_pkg::CMD_DESTROY, mcit_pkg::CMD_PAUSE, mcit_pkg::CMD_RESUME: begin
                r_slot <= in_id;
                if (id_ok && act[in_sid]) begin
                  if (in_cmd == mcit_pkg::CMD_DESTROY) begin
                    act[in_sid] <= 1'b0;
                    if (live != '0) live <= live - CW'(1);
                  end else begin
                    pau[in_sid] <= (in_cmd == mcit_pkg::CMD_PAUSE);
                  end
                end else begin
                  r_ok <= 1'b0;
                end
              end
              mcit_pkg::CMD_RESTART, mcit_pkg::CMD_SET_IVAL: begin
                r_slot <= in_id;
                if (id_ok && act[in_sid]) state <= S_MRD;
                else r_ok <= 1'b0;
              end
              mcit_pkg::CMD_QUERY: begin
                r_kind <= mcit_pkg::KIND_QUERY;
                r_slot <= in_id;
                if (id_ok) state <= S_MRD;
                else r_ok <= 1'b0;
              end
              mcit_pkg::CMD_PAUSE_ALL:  gpause <= 1'b1;
              mcit_pkg::CMD_RESUME_ALL: gpause <= 1'b0;
              mcit_pkg::CMD_KILL_ALL: begin
                act  <= '0;
                live <= '0;
              end
              default: r_ok <= 1'b0;
            endcase
          end
        end
        S_TRD: state <= S_TWR;
        S_TWR: begin
          if (t_fire) begin
            fired[ti] <= 1'b1;
            if (!rep[ti] || (rd_data.repeats == 16'd1)) begin
              act[ti] <= 1'b0;
              if (live != '0) live <= live - CW'(1);
            end
          end
          if (32'(idx) == NUM_SLOTS - 1) begin
            idx   <= '0;
            state <= S_TEMIT;
          end else begin
            idx   <= idx + CW'(1);
            state <= S_TRD;
          end
        end
        S_TEMIT: begin
          if (32'(idx) == NUM_SLOTS) begin
            r_kind <= mcit_pkg::KIND_DONE;
            r_ok   <= 1'b1;
            r_slot <= 4'd0;
            state  <= S_OUT;
          end else if (!fired[ti]) begin
            idx <= idx + CW'(1);
          end else if (out_free) begin
            m_tuser  <= mcit_pkg::KIND_FIRED;
            m_tlast  <= 1'b0;
            m_tdata  <= pack_out(1'b1, 4'(ti), '0, '0, '0, 1'b0, 1'b0,
                                 5'(live), total, gpause);
            idx      <= idx + CW'(1);
          end
        end
        S_MRD: state <= S_MWR;
        S_MWR: begin
          state <= S_OUT;
          if (cmd == mcit_pkg::CMD_QUERY) begin
            r_el  <= rd_data.elapsed;
            r_act <= act[sid];
            r_pau <= pau[sid];
            if (act[sid]) begin
              r_rem <= (rd_data.elapsed < rd_data.interval) ?
                       rd_data.interval - rd_data.elapsed : 32'd0;
              state <= S_QWAIT;
            end
          end
        end
        S_QWAIT: begin
          if (div_rsp.done) begin
            r_prog <= div_rsp.prog;
            state  <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            m_tuser  <= r_kind;
            m_tlast  <= 1'b1;
            m_tdata  <= pack_out(r_ok, r_slot, r_rem, r_el, r_prog, r_act, r_pau,
                                 5'(live), total, gpause);
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### sim/mcit_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcit_result_checker
// Watches both stream channels of the interval timer, predicts the results
// of every accepted command and compares them field by field.
// ----------------------------------------------------------------------------
module mcit_result_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [55:0]  s_tdata,
  input  logic [3:0]   s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [119:0] m_tdata,
  input  logic [1:0]   m_tuser,
  input  logic         m_tlast,
  output int           mismatches,
  output int           pending
);
  import mcit_pkg::*;

  localparam int SLOTS = NUM_SLOTS_DEF;

  typedef struct {
    logic [1:0]  kind;
    logic        ok;
    logic [3:0]  slot;
    logic [31:0] remaining;
    logic [31:0] elapsed_now;
    logic [6:0]  progress;
    logic        is_active;
    logic        is_paused;
    logic [4:0]  active_count;
    logic [31:0] total_elapsed;
    logic        system_paused;
    logic        last;
  } timer_result_t;

  timer_result_t expected_results[$];

  logic        active_q    [SLOTS];
  logic        paused_q    [SLOTS];
  logic        repeating_q [SLOTS];
  logic [31:0] interval_q  [SLOTS];
  logic [31:0] elapsed_q   [SLOTS];
  logic [15:0] repeats_q   [SLOTS];
  logic [31:0] total_q;
  logic        bank_paused_q;
  logic [4:0]  live_q;

  assign pending = expected_results.size();

  function automatic timer_result_t make_result(logic [1:0] kind, logic ok,
                                                logic [3:0] slot);
    timer_result_t r;
    r = '{default: '0};
    r.kind = kind;
    r.ok   = ok;
    r.slot = slot;
    return r;
  endfunction

  task automatic drop_live();
    if (live_q != 0) live_q = live_q - 1'b1;
  endtask

  task automatic predict_command(input logic [3:0] cmd, input logic [3:0] id,
                                 input logic [31:0] tv, input logic rep,
                                 input logic [15:0] cnt);
    timer_result_t batch[$];
    timer_result_t r;
    logic [32:0]   sum;
    logic [63:0]   prog;
    int            free_slot;
    logic          good;
    free_slot = -1;
    case (cmd)
      CMD_TICK: begin
        if (!bank_paused_q) begin
          total_q = total_q + tv;
          for (int i = 0; i < SLOTS; i++) begin
            if (active_q[i] && !paused_q[i]) begin
              sum = {1'b0, elapsed_q[i]} + {1'b0, tv};
              elapsed_q[i] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
              if (elapsed_q[i] >= interval_q[i]) begin
                batch.push_back(make_result(KIND_FIRED, 1'b1, 4'(i)));
                if (repeating_q[i]) begin
                  elapsed_q[i] = '0;
                  if (repeats_q[i] != 0) begin
                    repeats_q[i] = repeats_q[i] - 1'b1;
                    if (repeats_q[i] == 0) begin
                      active_q[i] = 1'b0;
                      drop_live();
                    end
                  end
                end else begin
                  active_q[i] = 1'b0;
                  drop_live();
                end
              end
            end
          end
        end
        batch.push_back(make_result(KIND_DONE, 1'b1, '0));
      end
      CMD_CREATE: begin
        for (int i = SLOTS - 1; i >= 0; i--)
          if (!active_q[i]) free_slot = i;
        if (free_slot < 0) begin
          batch.push_back(make_result(KIND_STATUS, 1'b0, '0));
        end else begin
          interval_q[free_slot]  = tv;
          elapsed_q[free_slot]   = '0;
          repeating_q[free_slot] = rep;
          repeats_q[free_slot]   = cnt;
          active_q[free_slot]    = 1'b1;
          paused_q[free_slot]    = 1'b0;
          live_q = live_q + 1'b1;
          batch.push_back(make_result(KIND_STATUS, 1'b1, 4'(free_slot)));
        end
      end
      CMD_DESTROY, CMD_PAUSE, CMD_RESUME, CMD_RESTART, CMD_SET_IVAL: begin
        good = active_q[id];
        if (good) begin
          case (cmd)
            CMD_DESTROY: begin
              active_q[id] = 1'b0;
              drop_live();
            end
            CMD_PAUSE:   paused_q[id] = 1'b1;
            CMD_RESUME:  paused_q[id] = 1'b0;
            CMD_RESTART: elapsed_q[id] = '0;
            default:     interval_q[id] = tv;
          endcase
        end
        batch.push_back(make_result(KIND_STATUS, good, id));
      end
      CMD_QUERY: begin
        r = make_result(KIND_QUERY, 1'b1, id);
        r.elapsed_now = elapsed_q[id];
        r.is_active   = active_q[id];
        r.is_paused   = paused_q[id];
        if (active_q[id]) begin
          if (elapsed_q[id] < interval_q[id]) r.remaining = interval_q[id] - elapsed_q[id];
          if (interval_q[id] != 0) begin
            prog = (64'(elapsed_q[id]) * PCT_FULL) / 64'(interval_q[id]);
            r.progress = (prog > PCT_FULL) ? 7'(PCT_FULL) : prog[6:0];
          end
        end
        batch.push_back(r);
      end
      CMD_PAUSE_ALL: begin
        bank_paused_q = 1'b1;
        batch.push_back(make_result(KIND_STATUS, 1'b1, '0));
      end
      CMD_RESUME_ALL: begin
        bank_paused_q = 1'b0;
        batch.push_back(make_result(KIND_STATUS, 1'b1, '0));
      end
      CMD_KILL_ALL: begin
        for (int i = 0; i < SLOTS; i++) active_q[i] = 1'b0;
        live_q = '0;
        batch.push_back(make_result(KIND_STATUS, 1'b1, '0));
      end
      default: batch.push_back(make_result(KIND_STATUS, 1'b0, '0));
    endcase
    foreach (batch[i]) begin
      batch[i].active_count  = live_q;
      batch[i].total_elapsed = total_q;
      batch[i].system_paused = bank_paused_q;
      batch[i].last          = (i == batch.size() - 1);
      expected_results.push_back(batch[i]);
    end
  endtask

  task automatic compare_result(input timer_result_t exp_r, input timer_result_t act_r);
    string       names [12];
    logic [31:0] ev    [12];
    logic [31:0] av    [12];
    logic        bad;
    names = '{"kind", "ok", "slot", "remaining", "elapsed_now", "progress",
              "is_active", "is_paused", "active_count", "total_elapsed",
              "system_paused", "last"};
    ev = '{exp_r.kind, exp_r.ok, exp_r.slot, exp_r.remaining, exp_r.elapsed_now,
           exp_r.progress, exp_r.is_active, exp_r.is_paused, exp_r.active_count,
           exp_r.total_elapsed, exp_r.system_paused, exp_r.last};
    av = '{act_r.kind, act_r.ok, act_r.slot, act_r.remaining, act_r.elapsed_now,
           act_r.progress, act_r.is_active, act_r.is_paused, act_r.active_count,
           act_r.total_elapsed, act_r.system_paused, act_r.last};
    bad = 1'b0;
    for (int i = 0; i < 12; i++) begin
      if (ev[i] !== av[i]) begin
        if (mismatches < 10)
          $display("mismatch %s: expected %0h, got %0h", names[i], ev[i], av[i]);
        bad = 1'b1;
      end
    end
    if (bad) mismatches++;
  endtask

  always @(posedge clk) begin
    timer_result_t act_r;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        active_q[i]    = 1'b0;
        paused_q[i]    = 1'b0;
        repeating_q[i] = 1'b0;
        interval_q[i]  = '0;
        elapsed_q[i]   = '0;
        repeats_q[i]   = '0;
      end
      total_q       = '0;
      bank_paused_q = 1'b0;
      live_q        = '0;
      mismatches    = 0;
    end else begin
      if (s_tvalid && s_tready)
        predict_command(s_tuser, s_tdata[3:0], s_tdata[35:4], s_tdata[36], s_tdata[52:37]);
      if (m_tvalid && m_tready) begin
        act_r.kind          = m_tuser;
        act_r.ok            = m_tdata[0];
        act_r.slot          = m_tdata[4:1];
        act_r.remaining     = m_tdata[36:5];
        act_r.elapsed_now   = m_tdata[68:37];
        act_r.progress      = m_tdata[75:69];
        act_r.is_active     = m_tdata[76];
        act_r.is_paused     = m_tdata[77];
        act_r.active_count  = m_tdata[82:78];
        act_r.total_elapsed = m_tdata[114:83];
        act_r.system_paused = m_tdata[115];
        act_r.last          = m_tlast;
        if (expected_results.size() == 0) begin
          if (mismatches < 10) $display("unexpected result transaction, kind %0d", m_tuser);
          mismatches++;
        end else begin
          compare_result(expected_results.pop_front(), act_r);
        end
      end
    end
  end

endmodule

### sim/multi_channel_interval_timer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_channel_interval_timer_tb
// Drives directed and random timer commands into the interval timer under
// varying back-pressure; a checker beside the block judges every result.
// ----------------------------------------------------------------------------
module multi_channel_interval_timer_tb;
  import mcit_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 400;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [55:0]  s_tdata = '0;
  logic [3:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [119:0] m_tdata;
  logic [1:0]   m_tuser;
  logic         m_tlast;
  int           mismatches;
  int           pending;
  int           send_idle_pct = 26;
  int           recv_idle_pct = 69;
  logic         hold_request = 1'b0;
  logic         hold_done = 1'b0;
  int           quiet_cycles = 0;

  always #6 clk = ~clk;

  multi_channel_interval_timer dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  mcit_result_checker checker_i (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast), .mismatches(mismatches), .pending(pending)
  );

  // Receiver: random stalls, or one long hold-off on request.
  always @(posedge clk) begin
    if (hold_request && !hold_done) begin
      m_tready <= 1'b0;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_done <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL multi_channel_interval_timer");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_command(input logic [3:0] cmd, input logic [3:0] id,
                              input logic [31:0] tv, input logic rep,
                              input logic [15:0] cnt);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {3'b000, cnt, rep, tv, id};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_random_command();
    logic [3:0]  cmd;
    logic [31:0] tv;
    logic [15:0] cnt;
    int          roll;
    roll = $urandom_range(99);
    if (roll < 30)      cmd = CMD_TICK;
    else if (roll < 48) cmd = CMD_CREATE;
    else if (roll < 55) cmd = CMD_QUERY;
    else if (roll < 60) cmd = CMD_DESTROY;
    else if (roll < 65) cmd = CMD_PAUSE;
    else if (roll < 70) cmd = CMD_RESUME;
    else if (roll < 75) cmd = CMD_RESTART;
    else if (roll < 80) cmd = CMD_SET_IVAL;
    else if (roll < 85) cmd = CMD_PAUSE_ALL;
    else if (roll < 92) cmd = CMD_RESUME_ALL;
    else if (roll < 95) cmd = CMD_KILL_ALL;
    else                cmd = 4'($urandom_range(15, 11));
    // keep ticks and intervals mostly on the same scale so slots fire
    case ($urandom_range(9))
      0:       tv = $urandom();
      1:       tv = 32'hFFFF_FFFF;
      2:       tv = '0;
      default: tv = $urandom_range(60);
    endcase
    cnt = ($urandom_range(9) == 0) ? 16'($urandom()) : 16'($urandom_range(3));
    send_command(cmd, 4'($urandom_range(15)), tv, 1'($urandom_range(1)), cnt);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: fill the bank so that every slot has been written once.
    send_command(CMD_TICK, 4'd0, 32'd5, 1'b0, 16'd0);
    send_command(CMD_CREATE, 4'd0, 32'd0, 1'b0, 16'd0);
    send_command(CMD_CREATE, 4'd0, 32'd1, 1'b1, 16'd2);
    send_command(CMD_CREATE, 4'd0, 32'hFFFF_FFFF, 1'b1, 16'hFFFF);
    for (int i = 3; i < 16; i++)
      send_command(CMD_CREATE, 4'd0, 32'(i * 3), 1'(i % 2), 16'(i % 3));
    send_command(CMD_CREATE, 4'd0, 32'd7, 1'b0, 16'd0);
    send_command(CMD_PAUSE, 4'd4, 32'd0, 1'b0, 16'd0);
    send_command(CMD_TICK, 4'd0, 32'd1, 1'b0, 16'd0);
    send_command(CMD_QUERY, 4'd5, 32'd0, 1'b0, 16'd0);
    send_command(CMD_RESUME, 4'd4, 32'd0, 1'b0, 16'd0);
    send_command(CMD_PAUSE_ALL, 4'd0, 32'd0, 1'b0, 16'd0);
    send_command(CMD_TICK, 4'd0, 32'd100, 1'b0, 16'd0);
    send_command(CMD_RESUME_ALL, 4'd0, 32'd0, 1'b0, 16'd0);
    send_command(CMD_RESTART, 4'd6, 32'd0, 1'b0, 16'd0);
    send_command(CMD_SET_IVAL, 4'd15, 32'hFFFF_FFFF, 1'b0, 16'd0);
    send_command(CMD_TICK, 4'd0, 32'hFFFF_FFFF, 1'b0, 16'd0);
    send_command(CMD_QUERY, 4'd2, 32'd0, 1'b0, 16'd0);
    send_command(CMD_DESTROY, 4'd0, 32'd0, 1'b0, 16'd0);
    send_command(4'd15, 4'd15, 32'd0, 1'b0, 16'd0);
    send_command(CMD_KILL_ALL, 4'd0, 32'd0, 1'b0, 16'd0);
    send_command(CMD_QUERY, 4'd0, 32'd0, 1'b0, 16'd0);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 69 : 0;
      recv_idle_pct = (phase == 0) ? 69 : (phase == 1) ? 26 : 0;
      for (int n = 0; n < 56; n++) begin
        if (phase == 0 && n == 20) hold_request <= 1'b1;
        if (phase == 1 && n == 35) begin
          s_tvalid <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
        send_random_command();
      end
    end
    s_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("PASS multi_channel_interval_timer");
    else
      $display("FAIL multi_channel_interval_timer");
    $finish;
  end

endmodule
